>>> rtl/yrsp_pkg.sv
`timescale 1ns / 1ps

package yrsp_pkg;

	// field and word widths
	localparam int SIG_W   = 32;
	localparam int GAIN_W  = 16;
	localparam int IN_W    = 24;
	localparam int TURN_W  = 16;
	localparam int ADDR_W  = 4;
	localparam int CFG_W   = 64;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [ADDR_W-1:0] REG_CMD_GAIN       = 4'd0;
	localparam logic [ADDR_W-1:0] REG_PF_IN_GAIN     = 4'd1;
	localparam logic [ADDR_W-1:0] REG_PF_FB_GAIN     = 4'd2;
	localparam logic [ADDR_W-1:0] REG_FORWARD_GAIN   = 4'd3;
	localparam logic [ADDR_W-1:0] REG_MODEL_GAINS    = 4'd4;
	localparam logic [ADDR_W-1:0] REG_LOOP_GAIN      = 4'd5;
	localparam logic [ADDR_W-1:0] REG_PRED_IN_GAIN   = 4'd6;
	localparam logic [ADDR_W-1:0] REG_PRED_GAINS     = 4'd7;

	// turn clamp, +/-100.0 in q8.8
	localparam logic signed [SIG_W-1:0] TURN_LIMIT = 32'sd25600;

	// rounding offset for the q2.14 product, half an lsb
	localparam logic signed [48:0] ROUND_HALF = 49'sd8192;

endpackage

>>> rtl/yaw_rate_smith_predictor.sv
`timescale 1ns / 1ps

// Yaw rate controller with a Smith-style predictor, one control tick per item.
// Input item on s_*: commanded and measured yaw rate, signed q16.8.
// Result item on m_*: turn value, signed q8.8, clamped to +/-100.0.
// Gains are written through cfg_we / cfg_addr / cfg_data, by the user only while
// the block is idle (the block does not enforce it); an index above 7 is dropped.
// All twelve q2.14 products of a tick go through one 32x16 multiplier, and
// all sums and differences through one saturating adder, stepped by a small
// sequencer. The multiplier is registered and its rounded result is used in the
// next state. A tick runs the compute states S_CMD to S_FAST, then S_OUT loads
// the output register; s_tready comes back in the same cycle as the result item
// shows, so a new item is accepted only after the last one has left the sequencer.
// s_tready is low for the whole tick. If the receiver stalls, the finished
// value waits in the sequencer until the output register is free; the output
// register itself holds its item until m_tready.
// Reset clears all gains, filter states and both delay lines to zero.
module yaw_rate_smith_predictor #(
	parameter int DELAY_STEPS = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// rate_command [23:0], rate_measured [47:24]
	input  logic [yrsp_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// turn_value [15:0]
	output logic [yrsp_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_we,
	input  logic [yrsp_pkg::ADDR_W-1:0]          cfg_addr,
	input  logic [yrsp_pkg::CFG_W-1:0]           cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD,
		S_SHAPE,
		S_CIN,
		S_PF,
		S_FF,
		S_TURN,
		S_MODEL,
		S_INT,
		S_SIN,
		S_SLOW_A,
		S_SLOW,
		S_FAST_A,
		S_FAST,
		S_OUT
	} state_t;

	state_t state_q;

	// gains
	logic signed [15:0] cmd_gain_q;
	logic signed [15:0] pf_in_gain_q;
	logic signed [15:0] pf_fb_gain_q;
	logic signed [15:0] forward_gain_q;
	logic        [31:0] model_gains_q;
	logic signed [15:0] loop_gain_q;
	logic signed [15:0] pred_in_gain_q;
	logic        [63:0] pred_gains_q;

	// latched input item
	logic signed [23:0] cmd_q;
	logic signed [23:0] meas_q;

	// controller state
	logic signed [31:0] pf_state_q;
	logic signed [31:0] model_state_q;
	logic signed [31:0] int_state_q;
	logic signed [31:0] fast_state_q;
	logic signed [31:0] slow_state_q;
	logic signed [31:0] pred_prev_q;
	logic signed [31:0] model_dly_q [DELAY_STEPS];
	logic signed [31:0] pred_dly_q  [DELAY_STEPS];

	// per-tick scratch
	logic signed [31:0] shaped_q;
	logic signed [31:0] ff_q;
	logic signed [31:0] cin_q;
	logic signed [31:0] sin_q;
	logic signed [31:0] tmp_q;
	logic signed [15:0] turn_q;

	// shared multiplier
	logic signed [31:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [47:0] prod_q;
	logic signed [48:0] prod_rnd;
	logic signed [34:0] prod_shr;
	logic signed [31:0] rsat;

	// shared saturating adder
	logic signed [31:0] alu_a;
	logic signed [31:0] alu_b;
	logic               alu_sub;
	logic signed [32:0] alu_wide;
	logic signed [31:0] alu_sum;
	logic signed [15:0] turn_clamp;

	logic out_free;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid || m_tready;

	// operand select for the multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CMD: begin
				mul_a = {{8{cmd_q[23]}}, cmd_q};
				mul_b = cmd_gain_q;
			end
			S_SHAPE: begin
				mul_a = pf_state_q;
				mul_b = pf_fb_gain_q;
			end
			S_CIN: begin
				mul_a = shaped_q;
				mul_b = pf_in_gain_q;
			end
			S_PF: begin
				mul_a = shaped_q;
				mul_b = forward_gain_q;
			end
			S_FF: begin
				mul_a = model_dly_q[DELAY_STEPS-1];
				mul_b = signed'(model_gains_q[31:16]);
			end
			S_TURN: begin
				mul_a = model_state_q;
				mul_b = signed'(model_gains_q[15:0]);
			end
			S_MODEL: begin
				mul_a = cin_q;
				mul_b = loop_gain_q;
			end
			S_INT: begin
				mul_a = int_state_q;
				mul_b = pred_in_gain_q;
			end
			S_SIN: begin
				mul_a = pred_dly_q[DELAY_STEPS-1];
				mul_b = signed'(pred_gains_q[31:16]);
			end
			S_SLOW_A: begin
				mul_a = slow_state_q;
				mul_b = signed'(pred_gains_q[15:0]);
			end
			S_SLOW: begin
				mul_a = sin_q;
				mul_b = signed'(pred_gains_q[63:48]);
			end
			S_FAST_A: begin
				mul_a = fast_state_q;
				mul_b = signed'(pred_gains_q[47:32]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up, floor by 2^14, saturate to 32 bits
	always_comb begin
		prod_rnd = {prod_q[47], prod_q} + yrsp_pkg::ROUND_HALF;
		prod_shr = prod_rnd[48:14];
		if (prod_shr[34:31] == 4'b0000 || prod_shr[34:31] == 4'b1111) begin
			rsat = prod_shr[31:0];
		end else if (prod_shr[34]) begin
			rsat = 32'sh8000_0000;
		end else begin
			rsat = 32'sh7fff_ffff;
		end
	end

	// operand select for the adder
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_CMD: begin
				alu_a = model_state_q;
				alu_b = {{8{meas_q[23]}}, meas_q};
			end
			S_SHAPE: begin
				alu_a   = rsat;
				alu_b   = pf_state_q;
				alu_sub = 1'b1;
			end
			S_CIN: begin
				alu_a   = cin_q;
				alu_b   = pred_prev_q;
				alu_sub = 1'b1;
			end
			S_PF, S_MODEL, S_SLOW, S_FAST: begin
				alu_a = rsat;
				alu_b = tmp_q;
			end
			S_FF: begin
				alu_a   = fast_state_q;
				alu_b   = slow_state_q;
				alu_sub = 1'b1;
			end
			S_TURN: begin
				alu_a = ff_q;
				alu_b = int_state_q;
			end
			S_INT: begin
				alu_a = rsat;
				alu_b = int_state_q;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	// saturating add or subtract, then the turn clamp
	always_comb begin
		if (alu_sub) begin
			alu_wide = {alu_a[31], alu_a} - {alu_b[31], alu_b};
		end else begin
			alu_wide = {alu_a[31], alu_a} + {alu_b[31], alu_b};
		end
		if (alu_wide[32] == alu_wide[31]) begin
			alu_sum = alu_wide[31:0];
		end else if (alu_wide[32]) begin
			alu_sum = 32'sh8000_0000;
		end else begin
			alu_sum = 32'sh7fff_ffff;
		end
		if (alu_sum > yrsp_pkg::TURN_LIMIT) begin
			turn_clamp = yrsp_pkg::TURN_LIMIT[15:0];
		end else if (alu_sum < -yrsp_pkg::TURN_LIMIT) begin
			turn_clamp = 16'(-yrsp_pkg::TURN_LIMIT);
		end else begin
			turn_clamp = alu_sum[15:0];
		end
	end

	// sequencer, gains, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cmd_gain_q     <= '0;
			pf_in_gain_q   <= '0;
			pf_fb_gain_q   <= '0;
			forward_gain_q <= '0;
			model_gains_q  <= '0;
			loop_gain_q    <= '0;
			pred_in_gain_q <= '0;
			pred_gains_q   <= '0;
			pf_state_q     <= '0;
			model_state_q  <= '0;
			int_state_q    <= '0;
			fast_state_q   <= '0;
			slow_state_q   <= '0;
			pred_prev_q    <= '0;
			for (int k = 0; k < DELAY_STEPS; k++) begin
				model_dly_q[k] <= '0;
				pred_dly_q[k]  <= '0;
			end
			cmd_q    <= '0;
			meas_q   <= '0;
			shaped_q <= '0;
			ff_q     <= '0;
			cin_q    <= '0;
			sin_q    <= '0;
			tmp_q    <= '0;
			turn_q   <= '0;
			prod_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			prod_q <= mul_a * mul_b;

			// configuration writes
			if (cfg_we) begin
				case (cfg_addr)
					yrsp_pkg::REG_CMD_GAIN:     cmd_gain_q     <= cfg_data[15:0];
					yrsp_pkg::REG_PF_IN_GAIN:   pf_in_gain_q   <= cfg_data[15:0];
					yrsp_pkg::REG_PF_FB_GAIN:   pf_fb_gain_q   <= cfg_data[15:0];
					yrsp_pkg::REG_FORWARD_GAIN: forward_gain_q <= cfg_data[15:0];
					yrsp_pkg::REG_MODEL_GAINS:  model_gains_q  <= cfg_data[31:0];
					yrsp_pkg::REG_LOOP_GAIN:    loop_gain_q    <= cfg_data[15:0];
					yrsp_pkg::REG_PRED_IN_GAIN: pred_in_gain_q <= cfg_data[15:0];
					yrsp_pkg::REG_PRED_GAINS:   pred_gains_q   <= cfg_data;
					default: ;
				endcase
			end

			// output register drains, unless refilled in the same cycle
			if (m_tvalid && m_tready && state_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tdata[23:0];
						meas_q  <= s_tdata[47:24];
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					// model output plus measured rate
					cin_q   <= alu_sum;
					state_q <= S_SHAPE;
				end
				S_SHAPE: begin
					shaped_q <= alu_sum;
					state_q  <= S_CIN;
				end
				S_CIN: begin
					// loop error, previous predictor output removed
					tmp_q   <= rsat;
					cin_q   <= alu_sum;
					state_q <= S_PF;
				end
				S_PF: begin
					pf_state_q <= alu_sum;
					state_q    <= S_FF;
				end
				S_FF: begin
					ff_q        <= rsat;
					pred_prev_q <= alu_sum;
					state_q     <= S_TURN;
				end
				S_TURN: begin
					// feedforward plus integrator output before its update
					tmp_q   <= rsat;
					turn_q  <= turn_clamp;
					state_q <= S_MODEL;
				end
				S_MODEL: begin
					model_state_q  <= alu_sum;
					model_dly_q[0] <= shaped_q;
					for (int k = 1; k < DELAY_STEPS; k++) begin
						model_dly_q[k] <= model_dly_q[k-1];
					end
					state_q <= S_INT;
				end
				S_INT: begin
					int_state_q <= alu_sum;
					state_q     <= S_SIN;
				end
				S_SIN: begin
					sin_q         <= rsat;
					pred_dly_q[0] <= rsat;
					for (int k = 1; k < DELAY_STEPS; k++) begin
						pred_dly_q[k] <= pred_dly_q[k-1];
					end
					state_q <= S_SLOW_A;
				end
				S_SLOW_A: begin
					tmp_q   <= rsat;
					state_q <= S_SLOW;
				end
				S_SLOW: begin
					slow_state_q <= alu_sum;
					state_q      <= S_FAST_A;
				end
				S_FAST_A: begin
					tmp_q   <= rsat;
					state_q <= S_FAST;
				end
				S_FAST: begin
					fast_state_q <= alu_sum;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					// wait for a free output slot
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= turn_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/yrsp_checker.sv
`timescale 1ns / 1ps

module yrsp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [yrsp_pkg::OUT_DATA_W-1:0]     m_tdata
);

	logic signed [31:0] turn_ext;

	assign turn_ext = signed'({{16{m_tdata[15]}}, m_tdata});

	// turn value never leaves the clamp range
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (turn_ext <= yrsp_pkg::TURN_LIMIT && turn_ext >= -yrsp_pkg::TURN_LIMIT))
		else $error("turn value outside clamp range");

	// one item at a time: ready drops right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready stayed high after an item was accepted");

	// a result cannot appear in the cycle right after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind yaw_rate_smith_predictor yrsp_checker u_yrsp_checker (.*);
